### rtl/core/bmg_pkg.sv
`default_nettype none
package bmg_pkg;
  localparam int UniformBitsDef = 32;
  localparam int OutFracBitsDef = 28;
  localparam int LogSteps = 32;
  localparam int TaylorTerms = 7;
  localparam logic [33:0] TwoLn2Q32 = 34'h162E42FF0;
  localparam logic [34:0] TwoPiQ32 = 35'h6487ED511;
  localparam logic [32:0] OneQ32 = 33'h100000000;

  // (a * b) >> 32, split to match the fixed-point truncation
  function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] hi;
    logic [63:0] lo;
    begin
      hi = (a >> 16) * b;
      lo = ((a & 64'hFFFF) * b) >> 16;
      mul_q32 = (hi + lo) >> 16;
    end
  endfunction

  // divisors of the Taylor terms, indexed by term number
  function automatic logic [7:0] sin_div(input logic [2:0] k);
    begin
      sin_div = 8'((2 * int'(k)) * (2 * int'(k) + 1));
    end
  endfunction

  function automatic logic [7:0] cos_div(input logic [2:0] k);
    begin
      cos_div = 8'((2 * int'(k) - 1) * (2 * int'(k)));
    end
  endfunction

  // work item flowing down the cell row
  typedef struct packed {
    logic [31:0] mant;     // Q1.30 (31 bits used)
    logic [31:0] frac;     // log2 fraction bits
    logic [6:0]  ipart;    // integer part of -log2
    logic [63:0] sq_rem;   // isqrt remainder
    logic [63:0] sq_res;   // isqrt partial root
    logic [63:0] ang;      // reduced angle, Q32
    logic [63:0] a2;
    logic [63:0] ts;
    logic [63:0] tc;
    logic signed [63:0] ss;
    logic signed [63:0] cc;
    logic [1:0]  quad;
    logic        swap;
  } bmg_work_t;
endpackage
`default_nettype wire

### rtl/core/bmg_if.sv
`default_nettype none
interface bmg_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] uniform_first;
  logic [31:0] uniform_second;
  modport source (output valid, uniform_first, uniform_second, input ready);
  modport sink (input valid, uniform_first, uniform_second, output ready);
endinterface

interface bmg_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] gauss_cos;
  logic signed [31:0] gauss_sin;
  modport source (output valid, gauss_cos, gauss_sin, input ready);
  modport sink (input valid, gauss_cos, gauss_sin, output ready);
endinterface
`default_nettype wire

### rtl/core/bmg_cell.sv
`default_nettype none
// One stage of a row. In the first row a cell resolves one log2 squaring bit;
// its early cells also carry the sine/cosine series, one cell multiplying a
// term by a^2 and the next dividing it by the factorial factors. In the
// second row a cell resolves one isqrt digit. Registered when en is high.
module bmg_cell
  import bmg_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  wire logic      clk,
  input  wire logic      en,
  input  wire bmg_work_t din,
  output bmg_work_t      dout
);
  localparam int SerLast = 2 * (TaylorTerms - 1);
  localparam bit SerMul = (STAGE >= 1) && (STAGE <= SerLast) && (STAGE % 2 == 1);
  localparam bit SerDiv = (STAGE >= 2) && (STAGE <= SerLast) && (STAGE % 2 == 0);
  localparam int Term = (SerMul || SerDiv) ? (STAGE + 1) / 2 : 1;
  localparam logic [63:0] SinDen = 64'(sin_div(3'(Term)));
  localparam logic [63:0] CosDen = 64'(cos_div(3'(Term)));
  localparam int SinSh = 32 + $clog2(SinDen);
  localparam int CosSh = 32 + $clog2(CosDen);
  // floor(n / d) for n < 2^32 is (n * ceil(2^sh / d)) >> sh with 2^(sh-32) >= d
  localparam logic [63:0] SinRcp = ((64'd1 << SinSh) + SinDen - 64'd1) / SinDen;
  localparam logic [63:0] CosRcp = ((64'd1 << CosSh) + CosDen - 64'd1) / CosDen;

  bmg_work_t w_nxt;
  bmg_work_t w_r;
  logic [63:0] sq;
  logic [63:0] bit_v;
  logic [63:0] trial;
  logic [95:0] qs;
  logic [95:0] qc;

  always_comb begin
    w_nxt = din;
    sq    = 64'(din.mant) * 64'(din.mant) >> 30;
    bit_v = 64'd0;
    trial = 64'd0;
    qs    = 96'd0;
    qc    = 96'd0;
    if (STAGE < LogSteps) begin
      w_nxt.frac = {din.frac[30:0], 1'b0};
      if (sq >= 64'h80000000) begin
        w_nxt.mant = 32'(sq >> 1);
        w_nxt.frac[0] = 1'b1;
      end else begin
        w_nxt.mant = 32'(sq);
      end
    end
    if (STAGE >= LogSteps && STAGE < LogSteps + 32) begin
      bit_v = 64'd1 << (62 - 2 * (STAGE - LogSteps));
      trial = din.sq_res + bit_v;
      if (din.sq_rem >= trial) begin
        w_nxt.sq_rem = din.sq_rem - trial;
        w_nxt.sq_res = (din.sq_res >> 1) + bit_v;
      end else begin
        w_nxt.sq_res = din.sq_res >> 1;
      end
    end
    if (SerMul) begin
      w_nxt.ts = mul_q32(din.ts, din.a2);
      w_nxt.tc = mul_q32(din.tc, din.a2);
    end
    // products stay below 2^32 since a < 1 in Q32
    if (SerDiv) begin
      qs = 96'(din.ts[31:0]) * 96'(SinRcp);
      qc = 96'(din.tc[31:0]) * 96'(CosRcp);
      w_nxt.ts = 64'(qs >> SinSh);
      w_nxt.tc = 64'(qc >> CosSh);
      if (Term % 2 == 1) begin
        w_nxt.ss = din.ss - $signed(w_nxt.ts);
        w_nxt.cc = din.cc - $signed(w_nxt.tc);
      end else begin
        w_nxt.ss = din.ss + $signed(w_nxt.ts);
        w_nxt.cc = din.cc + $signed(w_nxt.tc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r <= w_nxt;
    end
  end

  assign dout = w_r;
endmodule
`default_nettype wire

### rtl/core/box_muller_gaussian_pair.sv
// Channel | Dir | Handshake   | Payload
// in_ch   | in  | valid/ready | uniform_first, uniform_second (u32)
// out_ch  | out | valid/ready | gauss_cos, gauss_sin (s32, Q3.28)
// One pair per cycle sustained while the output is not stalled. Stages run in
// order: front (normalize, angle, series seed), a 32-cell row resolving one log2
// bit per cell (its early cells also run the sine/cosine series), log scale, a
// 32-cell row resolving one square-root digit per cell, and output stages.
// Synchronous active-low reset clears valid flags only.
// A stall on the output freezes the whole row; in_ready is out ready or no valid output.
`default_nettype none
module box_muller_gaussian_pair
  import bmg_pkg::*;
#(
  parameter int UNIFORM_BITS  = UniformBitsDef,
  parameter int OUT_FRAC_BITS = OutFracBitsDef
) (
  input wire logic clk,
  input wire logic rst_n,
  bmg_in_if.sink   in_ch,
  bmg_out_if.source out_ch
);
  localparam int NCell = 32;
  localparam int Lat = 2 * NCell + 5;

  logic            adv;
  logic [Lat-1:0]  vld_r;
  logic [Lat-1:0]  vld_nxt;

  // stage A: log normalize and angle reduce
  logic [63:0] x;
  logic [63:0] p;
  logic [5:0]  k;
  logic [29:0] f;
  logic [63:0] fa;
  bmg_work_t   a_nxt;
  bmg_work_t   a_r;

  always_comb begin
    x = 64'(in_ch.uniform_first) & ((64'd1 << UNIFORM_BITS) - 64'd1);
    if (x == 64'd0) x = 64'd1;
    k = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) k = 6'(i);
    end
    p = 64'(in_ch.uniform_second) & ((64'd1 << UNIFORM_BITS) - 64'd1);
    if (UNIFORM_BITS >= 32) p = p >> (UNIFORM_BITS - 32);
    else p = p << (32 - UNIFORM_BITS);
    f = p[29:0];
    a_nxt = '0;
    if (k >= 6'd30) a_nxt.mant = 32'(x >> (k - 6'd30));
    else a_nxt.mant = 32'(x << (6'd30 - k));
    a_nxt.ipart = 7'(UNIFORM_BITS - int'(k));
    a_nxt.quad = p[31:30];
    a_nxt.swap = (f > 30'h20000000);
    fa = a_nxt.swap ? (64'h40000000 - 64'(f)) : 64'(f);
    a_nxt.ang = mul_q32(fa, 64'(TwoPiQ32));
  end

  // stage B: a^2 and series seed
  bmg_work_t b_nxt;
  bmg_work_t b_r;
  always_comb begin
    b_nxt = a_r;
    b_nxt.a2 = mul_q32(a_r.ang, a_r.ang);
    b_nxt.ts = a_r.ang;
    b_nxt.tc = 64'(OneQ32);
    b_nxt.ss = $signed(a_r.ang);
    b_nxt.cc = $signed(64'(OneQ32));
  end

  bmg_work_t row [NCell+1];
  assign row[0] = b_r;

  for (genvar g = 0; g < NCell; g++) begin : g_row
    bmg_cell #(.STAGE(g)) u_cell (
      .clk(clk), .en(adv), .din(row[g]), .dout(row[g+1]));
  end

  // log chain runs ahead of isqrt: row feeds log, isqrt runs in tail row
  bmg_work_t c_nxt;
  bmg_work_t c_r;
  logic [63:0] lq;
  always_comb begin
    c_nxt = row[NCell];
    lq = {25'd0, row[NCell].ipart, 32'd0} - 64'(row[NCell].frac);
    c_nxt.sq_rem = mul_q32(lq, 64'(TwoLn2Q32)) << 24;
    c_nxt.sq_res = 64'd0;
  end

  bmg_work_t row2 [NCell+1];
  assign row2[0] = c_r;
  for (genvar g = 0; g < NCell; g++) begin : g_sq
    bmg_cell #(.STAGE(LogSteps + g)) u_sq (
      .clk(clk), .en(adv), .din(row2[g]), .dout(row2[g+1]));
  end

  // output stage: rotate and scale
  bmg_work_t       d_in;
  logic signed [63:0] c0, s0, cz, sz;
  logic [31:0]     oc_nxt, os_nxt, oc_r, os_r;
  bmg_work_t       e_r;

  function automatic logic [31:0] scale_out(input logic [63:0] radius,
                                            input logic signed [63:0] trig);
    logic        neg;
    logic [63:0] mag, lim, v;
    begin
      neg = trig < 0;
      mag = neg ? 64'(-trig) : 64'(trig);
      lim = neg ? 64'h80000000 : 64'h7FFFFFFF;
      v = mul_q32(radius, mag);
      if (OUT_FRAC_BITS >= 28) begin
        if (v > (lim >> (OUT_FRAC_BITS - 28))) v = lim;
        else v = v << (OUT_FRAC_BITS - 28);
      end else begin
        v = v >> (28 - OUT_FRAC_BITS);
        if (v > lim) v = lim;
      end
      if (neg) v = 64'd0 - v;
      scale_out = v[31:0];
    end
  endfunction

  // undo the octant swap, then rotate by quadrant
  assign d_in = e_r;
  always_comb begin
    c0 = d_in.swap ? d_in.ss : d_in.cc;
    s0 = d_in.swap ? d_in.cc : d_in.ss;
    case (d_in.quad)
      2'd0: begin cz = c0;  sz = s0;  end
      2'd1: begin cz = -s0; sz = c0;  end
      2'd2: begin cz = -c0; sz = -s0; end
      default: begin cz = s0; sz = -c0; end
    endcase
    oc_nxt = scale_out(d_in.sq_res, cz);
    os_nxt = scale_out(d_in.sq_res, sz);
  end

  assign adv = !vld_r[Lat-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_comb begin
    vld_nxt = {vld_r[Lat-2:0], in_ch.valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
    if (adv) begin
      a_r  <= a_nxt;
      b_r  <= b_nxt;
      c_r  <= c_nxt;
      e_r  <= row2[NCell];
      oc_r <= oc_nxt;
      os_r <= os_nxt;
    end
  end

  assign out_ch.valid     = vld_r[Lat-1];
  assign out_ch.gauss_cos = oc_r;
  assign out_ch.gauss_sin = os_r;
endmodule
`default_nettype wire

### rtl/core/bmg_checker.sv
`default_nettype none
module bmg_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_cos,
  input wire logic [31:0] out_sin
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cos) && $stable(out_sin))
    else $error("output changed under stall");
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");
endmodule

bind box_muller_gaussian_pair bmg_checker u_bmg_checker (
  .clk(clk), .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_cos(out_ch.gauss_cos), .out_sin(out_ch.gauss_sin));
`default_nettype wire
